### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, command and status codes, and the control word that the top
// level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY   = 64;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int NODE_BITS  = 10;
   localparam int INDEX_BITS = 11;
   localparam int COST_BITS  = 31;
   localparam int KEY_BITS   = COST_BITS + 1;

   localparam logic [INDEX_BITS-1:0] NONE_INDEX = {INDEX_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NOP     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [NODE_BITS-1:0]  node;
      logic [INDEX_BITS-1:0] parent;
      logic [COST_BITS-1:0]  path;
      logic [COST_BITS-1:0]  estimate;
   } entry_type;

   // one-hot per cycle at most; all low means hold
   typedef struct packed {
      logic insert;
      logic extract;
      logic clear;
   } cell_op_type;

endpackage

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: min-priority queue held as a sorted chain of cells
//
// Input channel (req_*): one command word per handshake: insert, extract
// minimum, clear or no-op. Insert's key is path_cost + estimate_cost; equal keys
// leave in arrival order. Result channel (rsp_*): exactly one word per
// command, carrying status, the extracted entry (or -1 / zero), and the
// occupancy after the command.
// The edge that accepts a command registers it and forms the key. Once the
// result register is free or draining, the command executes: an edge updates
// all CAPACITY cells at once (each compares its key against the new one and
// shifts) and loads the result register.
// Throughput: one command per cycle while the receiver keeps rsp_ready high.
// Stall: while a result waits, one more command is taken and held in the
// command stage; req_ready then drops until the result is taken.
// Reset: synchronous; empties the queue (all valid bits and the count) and
// drops any pending command or result. Entry contents are not cleared.
// Insert into a full queue is dropped with status full; extract on an empty
// queue returns status empty.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [9:0]  req_node_id,
   input  logic [30:0] req_path_cost,
   input  logic [30:0] req_estimate_cost,
   input  logic [10:0] req_parent_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_out_node,
   output logic [30:0] rsp_out_path_cost,
   output logic [30:0] rsp_out_estimate,
   output logic [31:0] rsp_out_total,
   output logic [10:0] rsp_out_parent,
   output logic [6:0]  rsp_occupancy
);

   localparam int CAP = spq_pkg::CAPACITY;
   localparam logic [spq_pkg::COUNT_BITS-1:0] FULL_COUNT = spq_pkg::COUNT_BITS'(CAP);

   // command stage
   logic                     pend_ff;
   spq_pkg::command_type     cmd_ff;
   spq_pkg::entry_type       new_ff;

   // result register
   logic                     rsp_valid_ff;
   spq_pkg::status_type      status_ff;
   spq_pkg::entry_type       out_ff;
   logic [spq_pkg::COUNT_BITS-1:0] occ_ff;
   logic                     none_ff;   // result carries no extracted entry

   logic [spq_pkg::COUNT_BITS-1:0] count_ff, count_in;

   logic                     fire;
   logic                     accept;
   spq_pkg::cell_op_type     op;
   spq_pkg::status_type      status_in;
   spq_pkg::entry_type       out_in;

   spq_pkg::entry_type       cell_entry [CAP];
   logic                     cell_valid [CAP];
   logic                     cell_keeps [CAP];

   // the pending command executes when the result register is free or draining
   assign fire      = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      op        = '0;
      status_in = spq_pkg::STATUS_DONE;
      count_in  = count_ff;
      out_in    = '0;
      out_in.node   = '1;   // replaced by the none index at the output
      out_in.parent = spq_pkg::NONE_INDEX;
      if (fire) begin
         unique case (cmd_ff)
            spq_pkg::CMD_INSERT: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = spq_pkg::STATUS_FULL;
               end else begin
                  op.insert = 1'b1;
                  count_in  = count_ff + spq_pkg::COUNT_BITS'(1);
               end
            end
            spq_pkg::CMD_EXTRACT: begin
               if (count_ff == '0) begin
                  status_in = spq_pkg::STATUS_EMPTY;
               end else begin
                  op.extract = 1'b1;
                  count_in   = count_ff - spq_pkg::COUNT_BITS'(1);
                  out_in     = cell_entry[0];
               end
            end
            spq_pkg::CMD_CLEAR: begin
               op.clear = 1'b1;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      spq_pkg::entry_type prev_e, next_e;
      logic               prev_v, prev_k, next_v;
      if (i == 0) begin : g_head
         // virtual left neighbor is always full and always keeps
         assign prev_e = new_ff;
         assign prev_v = 1'b1;
         assign prev_k = 1'b1;
      end else begin : g_body
         assign prev_e = cell_entry[i-1];
         assign prev_v = cell_valid[i-1];
         assign prev_k = cell_keeps[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign next_e = cell_entry[i];
         assign next_v = 1'b0;
      end else begin : g_mid
         assign next_e = cell_entry[i+1];
         assign next_v = cell_valid[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_entry  (new_ff),
         .prev_entry (prev_e),
         .prev_valid (prev_v),
         .prev_keeps (prev_k),
         .next_entry (next_e),
         .next_valid (next_v),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .keeps      (cell_keeps[i])
      );
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff          <= spq_pkg::command_type'(req_command);
         new_ff.node     <= req_node_id;
         new_ff.parent   <= req_parent_id;
         new_ff.path     <= req_path_cost;
         new_ff.estimate <= req_estimate_cost;
         new_ff.key      <= {1'b0, req_path_cost} + {1'b0, req_estimate_cost};
      end
      if (fire) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         occ_ff    <= count_in;
         none_ff   <= !op.extract;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (fire) begin
            pend_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         count_ff <= count_in;
      end
   end

   // a held node is non-negative; -1 when nothing was extracted
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_node      = none_ff ? spq_pkg::NONE_INDEX : {1'b0, out_ff.node};
   assign rsp_out_path_cost = out_ff.path;
   assign rsp_out_estimate  = out_ff.estimate;
   assign rsp_out_total     = out_ff.key;
   assign rsp_out_parent    = out_ff.parent;
   assign rsp_occupancy     = 7'(occ_ff);

endmodule

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry and its valid bit. On insert it keeps its entry, takes the
// new one, or takes its left neighbor's; on extract it takes its right
// neighbor's; on clear it drops its valid bit.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                clock,
   input  logic                reset,
   input  spq_pkg::cell_op_type op,
   input  spq_pkg::entry_type  new_entry,
   input  spq_pkg::entry_type  prev_entry,
   input  logic                prev_valid,
   input  logic                prev_keeps,
   input  spq_pkg::entry_type  next_entry,
   input  logic                next_valid,
   output spq_pkg::entry_type  entry,
   output logic                valid,
   output logic                keeps
);

   spq_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;

   // a valid entry stays put when it sorts at or before the new key
   assign keeps = valid_ff && (entry_ff.key <= new_entry.key);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (op.clear) begin
         valid_in = 1'b0;
      end else if (op.insert) begin
         valid_in = valid_ff || prev_valid;
         if (!keeps) begin
            entry_in = prev_keeps ? new_entry : prev_entry;
         end
      end else if (op.extract) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
